// ----- design/kln64_pkg.sv -----
package kln64_pkg;

    localparam int unsigned ROUNDS    = 12;
    localparam int unsigned BLOCK_W   = 64;
    localparam int unsigned RC_W      = 8;
    localparam logic [7:0]  GF_REDUCE = 8'h1B;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [RC_W-1:0]    rcon_t;

    localparam logic [3:0] SBOX [0:15] = '{
        4'h7, 4'h4, 4'hA, 4'h9, 4'h1, 4'hF, 4'hB, 4'h0,
        4'hC, 4'h3, 4'h2, 4'h6, 4'h8, 4'hE, 4'hD, 4'h5
    };

    function automatic logic [7:0] sbox_byte(input logic [7:0] v);
        return {SBOX[v[7:4]], SBOX[v[3:0]]};
    endfunction

    function automatic block_t sub_nibbles(input block_t s);
        block_t r;
        for (int k = 0; k < 16; k++)
        begin
            r[4*k +: 4] = SBOX[s[4*k +: 4]];
        end
        return r;
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_REDUCE : 8'h00);
    endfunction

    // One column, byte 0 in the top bits.
    function automatic logic [31:0] mix_column(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
        a0 = c[31:24];
        a1 = c[23:16];
        a2 = c[15:8];
        a3 = c[7:0];
        d0 = gf_double(a0);
        d1 = gf_double(a1);
        d2 = gf_double(a2);
        d3 = gf_double(a3);
        return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
                d1 ^ d2 ^ a2 ^ a3 ^ a0,
                d2 ^ d3 ^ a3 ^ a0 ^ a1,
                d3 ^ d0 ^ a0 ^ a1 ^ a2};
    endfunction

    function automatic logic [7:0] key_byte(input block_t k, input int unsigned i);
        return k[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic block_t key_next(input block_t k, input rcon_t rc);
        return {key_byte(k, 5),
                key_byte(k, 6),
                key_byte(k, 7) ^ rc,
                key_byte(k, 4),
                key_byte(k, 1) ^ key_byte(k, 5),
                sbox_byte(key_byte(k, 2) ^ key_byte(k, 6)),
                sbox_byte(key_byte(k, 3) ^ key_byte(k, 7)),
                key_byte(k, 0) ^ key_byte(k, 4)};
    endfunction

endpackage

// ----- design/kln64_round.sv -----
module kln64_round
    import kln64_pkg::*;
(
    input  block_t state_in,
    input  block_t rkey_in,
    input  rcon_t  rc,
    output block_t state_out,
    output block_t rkey_out
);

    block_t subbed;
    block_t rotated;

    // add round key, substitute, rotate left by two bytes, mix both columns
    assign subbed    = sub_nibbles(state_in ^ rkey_in);
    assign rotated   = {subbed[47:0], subbed[63:48]};
    assign state_out = {mix_column(rotated[63:32]), mix_column(rotated[31:0])};
    assign rkey_out  = key_next(rkey_in, rc);

endmodule

// ----- design/klein64_block_encrypt.sv -----
// KLEIN-64 encryption, one 64-bit block per word.
//
// Key: write the 64-bit key with cfg_wr_en / cfg_wr_data while the block is
// idle. It is used for every block that follows; reset clears it to zero.
//
// Input channel: in_valid / in_stall / plain_block. A word is taken at a
// clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall / cipher_block, same rules.
//
// The input register feeds the full chain of 12 unrolled rounds plus the
// final key add, which lands in the output register. Throughput is one
// word per cycle while out_stall is low.
//
// When the receiver stalls, the output register holds its word; the input
// register keeps accepting while the output register is free to advance,
// and in_stall rises only when both registers are full and out_stall is high.
// Reset empties both registers and drops both valids.
module klein64_block_encrypt
    import kln64_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_wr_en,
    input  block_t cfg_wr_data,
    input  logic   in_valid,
    output logic   in_stall,
    input  block_t plain_block,
    output logic   out_valid,
    input  logic   out_stall,
    output block_t cipher_block
);

    block_t key_reg;
    logic   in_valid_reg;
    block_t in_block_reg;
    logic   out_valid_reg;
    block_t out_block_reg;
    block_t out_block_next;

    logic   in_move;
    logic   out_free;

    block_t st_chain [0:ROUNDS];
    block_t rk_chain [0:ROUNDS];

    // output register can take a new word when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;
    // advance the input register into the output register
    assign in_move  = in_valid_reg && out_free;
    // hold off the sender only when the input register cannot drain
    assign in_stall = in_valid_reg && !out_free;

    assign out_valid    = out_valid_reg;
    assign cipher_block = out_block_reg;

    // unrolled round chain; the key schedule runs alongside from the key register
    assign st_chain[0] = in_block_reg;
    assign rk_chain[0] = key_reg;

    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        kln64_round u_round (
            .state_in  (st_chain[r]),
            .rkey_in   (rk_chain[r]),
            .rc        (RC_W'(r + 1)),
            .state_out (st_chain[r+1]),
            .rkey_out  (rk_chain[r+1])
        );
    end

    assign out_block_next = st_chain[ROUNDS] ^ rk_chain[ROUNDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            key_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_block_reg <= plain_block;
        end
        if (in_move)
        begin
            out_block_reg <= out_block_next;
        end
    end

    // a stalled input word stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !in_move |=> in_valid_reg && $stable(in_block_reg))
        else $error("input register lost a word while blocked");

    // an advancing word always reaches the output register
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_move |=> out_valid_reg)
        else $error("word dropped between input and output registers");

    // an accepted word is captured
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_valid_reg)
        else $error("accepted word not captured");

    // a drained output with nothing behind it goes empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !in_valid_reg |=> !out_valid_reg)
        else $error("output word repeated");

endmodule

// ----- tb/sv/klein64_checker.sv -----
`timescale 1ns / 100ps

module klein64_checker
    import kln64_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_wr_en,
    input  block_t cfg_wr_data,
    input  logic   in_valid,
    input  logic   in_stall,
    input  block_t plain_block,
    input  logic   out_valid,
    input  logic   out_stall,
    input  block_t cipher_block,
    output int     pending_words,
    output int     fail_count
);

    localparam logic [3:0] NIB_SUB [16] = '{
        4'h7, 4'h4, 4'hA, 4'h9, 4'h1, 4'hF, 4'hB, 4'h0,
        4'hC, 4'h3, 4'h2, 4'h6, 4'h8, 4'hE, 4'hD, 4'h5
    };

    block_t key_shadow;
    block_t cipher_q [$];
    int     mismatches;

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] b);
        return {NIB_SUB[b[7:4]], NIB_SUB[b[3:0]]};
    endfunction

    function automatic block_t klein_encrypt(input block_t pt, input block_t key);
        block_t     st;
        block_t     rk;
        logic [7:0] a [4];
        logic [7:0] d [4];
        logic [7:0] k [8];
        st = pt;
        rk = key;
        for (int r = 1; r <= ROUNDS; r++)
        begin
            st = st ^ rk;
            for (int n = 0; n < 16; n++)
            begin
                st[4*n +: 4] = NIB_SUB[st[4*n +: 4]];
            end
            st = {st[47:0], st[63:48]};
            // two 32-bit columns, byte 0 on top
            for (int c = 0; c < 2; c++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    a[i] = st[63-32*c-8*i -: 8];
                    d[i] = xtime(a[i]);
                end
                st[63-32*c -: 32] = {d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3],
                                     d[1] ^ d[2] ^ a[2] ^ a[3] ^ a[0],
                                     d[2] ^ d[3] ^ a[3] ^ a[0] ^ a[1],
                                     d[3] ^ d[0] ^ a[0] ^ a[1] ^ a[2]};
            end
            for (int i = 0; i < 8; i++)
            begin
                k[i] = rk[63-8*i -: 8];
            end
            rk = {k[5], k[6], k[7] ^ 8'(r), k[4],
                  k[1] ^ k[5], sub_byte(k[2] ^ k[6]), sub_byte(k[3] ^ k[7]),
                  k[0] ^ k[4]};
        end
        return st ^ rk;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_shadow = '0;
            cipher_q.delete();
            mismatches = 0;
            pending_words <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                cipher_q.push_back(klein_encrypt(plain_block, key_shadow));
            end
            if (out_valid && !out_stall)
            begin
                if (cipher_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: cipher_block %h with no word expected",
                             $time, cipher_block);
                end
                else if (cipher_block !== cipher_q[0])
                begin
                    mismatches++;
                    $display("%0t: cipher_block expected %h, actual %h",
                             $time, cipher_q[0], cipher_block);
                    void'(cipher_q.pop_front());
                end
                else
                begin
                    void'(cipher_q.pop_front());
                end
            end
            if (cfg_wr_en)
            begin
                key_shadow = cfg_wr_data;
            end
            pending_words <= cipher_q.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import kln64_pkg::*;

    // Pipeline is two registers deep; leave a few extra cycles after the
    // last word drains before touching the key or ending the run.
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS   = 125;

    // Directed plaintexts: the extremes, single bits at both ends, byte
    // patterns with and without the top bit set (which drives the GF
    // reduction in the column mix), and every nibble value in order.
    localparam block_t DIRECTED [12] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
        64'h8080_8080_8080_8080, 64'h7F7F_7F7F_7F7F_7F7F,
        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
        64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
        64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF
    };

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   cfg_wr_en   = 1'b0;
    block_t cfg_wr_data = '0;
    logic   in_valid    = 1'b0;
    logic   in_stall;
    block_t plain_block = '0;
    logic   out_valid;
    logic   out_stall   = 1'b0;
    block_t cipher_block;

    // Idling switch, shared by the sender and the receiver.
    logic   idle_on     = 1'b1;
    int     pending_words;
    int     fail_count;
    int     cycle_count = 0;

    klein64_block_encrypt i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .plain_block  (plain_block),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cipher_block (cipher_block)
    );

    klein64_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .plain_block   (plain_block),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cipher_block  (cipher_block),
        .pending_words (pending_words),
        .fail_count    (fail_count)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hold reset at start, then release it on a rising edge.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: stall in random bursts while idling is on, otherwise
    // keep taking every word.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one word and hold it until the block takes it. Valid stays
    // high on return so back-to-back words stream without a bubble.
    task automatic send_word(input block_t w);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        plain_block <= w;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Drop valid and wait until every expected word has come out. The
    // first edge lets the checker's count catch up with the last accept.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the key only once the pipeline is empty.
    task automatic load_key(input block_t k);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic block_t rand_block();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return block_t'(1) << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        block_t key;
        @(posedge rst_n);
        repeat (3) @(posedge clk);

        // Directed words under the reset key of zero, then under all ones.
        for (int i = 0; i < 12; i++)
        begin
            send_word(DIRECTED[i]);
        end
        load_key('1);
        for (int i = 0; i < 12; i++)
        begin
            send_word(DIRECTED[i]);
        end

        // Random phases, each under its own key. The first phases pin the
        // key extremes; the last ones run with no idling at all.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: key = '0;
                1: key = 64'h8000_0000_0000_0001;
                2: key = '1;
                default: key = {$urandom, $urandom};
            endcase
            load_key(key);
            idle_on <= (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                send_word(rand_block());
            end
        end

        drain();
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
